/* design/tcc_pkg.sv */
// Package for the text console cursor control core: codes, constants and types.
package tcc_pkg;

  // Field widths fixed by the word formats
  localparam int CHAR_W  = 8;
  localparam int GLYPH_W = 7;
  localparam int POS_W   = 8;

  // Default screen geometry
  localparam int DEF_COLUMNS = 40;
  localparam int DEF_ROWS    = 25;

  // Command queue geometry
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // Console byte codes
  localparam logic [CHAR_W-1:0] CH_BEL       = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC       = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [CHAR_W-1:0] CSI_FINAL_LO = 8'h40;
  localparam logic [CHAR_W-1:0] CSI_FINAL_HI = 8'h7E;
  localparam logic [CHAR_W-1:0] PRINT_LO     = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI     = 8'h7E;

  // Glyph codes
  localparam logic [GLYPH_W-1:0] GLYPH_SPACE    = 7'h20;
  localparam logic [GLYPH_W-1:0] GLYPH_QUESTION = 7'h3F;

  // Tab stops every eight columns
  localparam logic [2:0] TAB_MASK = 3'd7;

  // Event kinds
  localparam logic EV_DRAW   = 1'b0;
  localparam logic EV_SCROLL = 1'b1;

  // Commands from the front to the back
  typedef enum logic [2:0] {
    OP_GLYPH = 3'd0,
    OP_TAB   = 3'd1,
    OP_LF    = 3'd2,
    OP_CR    = 3'd3,
    OP_BS    = 3'd4
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [GLYPH_W-1:0] glyph;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Escape tracking
  typedef enum logic [2:0] {
    PH_NONE = 3'b001,
    PH_ESC  = 3'b010,
    PH_CSI  = 3'b100
  } phase_t;

  // Back sequencer
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } back_state_t;

endpackage

/* design/tcc_if.sv */
// Channel interfaces: console byte input and console event output.
interface tcc_in_if;
  logic                      valid;
  logic                      ready;
  logic [tcc_pkg::CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface tcc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       event_kind;
  logic [tcc_pkg::POS_W-1:0]   cell_column;
  logic [tcc_pkg::POS_W-1:0]   cell_row;
  logic [tcc_pkg::GLYPH_W-1:0] glyph_code;
  logic                       last_of_run;

  modport source (output valid, output event_kind, output cell_column, output cell_row,
                  output glyph_code, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input cell_column, input cell_row,
                  input glyph_code, input last_of_run, output ready);
endinterface

/* design/tcc_front.sv */
// Front end: accepts console bytes, tracks escape sequences, queues commands.
module tcc_front (
  input  logic               clk,
  input  logic               rst,
  tcc_in_if.sink             console,
  input  tcc_pkg::q_status_t q_status,
  output logic               push,
  output tcc_pkg::cmd_t      push_cmd
);

  tcc_pkg::phase_t             phase;
  tcc_pkg::phase_t             phase_next;
  logic [tcc_pkg::CHAR_W-1:0]  ch;
  logic                        accept;
  logic                        want_push;

  assign ch             = console.char_in;
  assign console.ready  = !q_status.full;
  assign accept         = console.valid && console.ready;
  assign push           = accept && want_push;

  // Classify the byte
  always_comb begin
    phase_next     = phase;
    want_push      = 1'b0;
    push_cmd.op    = tcc_pkg::OP_GLYPH;
    push_cmd.glyph = tcc_pkg::GLYPH_SPACE;
    unique case (phase)
      tcc_pkg::PH_ESC: begin
        phase_next = (ch == tcc_pkg::CH_LBRACKET) ? tcc_pkg::PH_CSI : tcc_pkg::PH_NONE;
      end
      tcc_pkg::PH_CSI: begin
        if (ch >= tcc_pkg::CSI_FINAL_LO && ch <= tcc_pkg::CSI_FINAL_HI) begin
          phase_next = tcc_pkg::PH_NONE;
        end
      end
      default: begin
        phase_next = tcc_pkg::PH_NONE;
        priority case (ch)
          tcc_pkg::CH_ESC: begin
            phase_next = tcc_pkg::PH_ESC;
          end
          tcc_pkg::CH_LF: begin
            want_push   = 1'b1;
            push_cmd.op = tcc_pkg::OP_LF;
          end
          tcc_pkg::CH_CR: begin
            want_push   = 1'b1;
            push_cmd.op = tcc_pkg::OP_CR;
          end
          tcc_pkg::CH_TAB: begin
            want_push   = 1'b1;
            push_cmd.op = tcc_pkg::OP_TAB;
          end
          tcc_pkg::CH_BS: begin
            want_push   = 1'b1;
            push_cmd.op = tcc_pkg::OP_BS;
          end
          tcc_pkg::CH_BEL: begin
            want_push = 1'b0;
          end
          default: begin
            want_push   = 1'b1;
            push_cmd.op = tcc_pkg::OP_GLYPH;
            if (ch < tcc_pkg::PRINT_LO || ch > tcc_pkg::PRINT_HI) begin
              push_cmd.glyph = tcc_pkg::GLYPH_QUESTION;
            end else begin
              push_cmd.glyph = ch[tcc_pkg::GLYPH_W-1:0];
            end
          end
        endcase
      end
    endcase
  end

  // Advance escape phase on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tcc_pkg::PH_NONE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

endmodule

/* design/tcc_queue.sv */
// Command queue between the front end and the back end.
module tcc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tcc_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output tcc_pkg::cmd_t      pop_cmd,
  output tcc_pkg::q_status_t q_status
);

  localparam int DEPTH = tcc_pkg::CQ_DEPTH;

  tcc_pkg::cmd_t                mem [DEPTH];
  logic [tcc_pkg::CQ_AW-1:0]    wptr;
  logic [tcc_pkg::CQ_AW-1:0]    rptr;
  logic [tcc_pkg::CQ_CW-1:0]    count;

  assign q_status.full  = (count == tcc_pkg::CQ_CW'(DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_cmd        = mem[rptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == tcc_pkg::CQ_AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == tcc_pkg::CQ_AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full)) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_status.empty)) else $error("queue read while empty");

endmodule

/* design/tcc_back.sv */
// Back end: executes cursor commands and emits draw and scroll words.
module tcc_back #(
  parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  tcc_pkg::q_status_t q_status,
  input  tcc_pkg::cmd_t      pop_cmd,
  output logic               pop,
  tcc_out_if.source          events
);

  localparam logic [tcc_pkg::POS_W-1:0] COL_LIMIT = tcc_pkg::POS_W'(COLUMNS);
  localparam logic [tcc_pkg::POS_W-1:0] ROW_LAST  = tcc_pkg::POS_W'(ROWS - 1);

  tcc_pkg::back_state_t          state;
  tcc_pkg::back_state_t          state_next;
  tcc_pkg::op_t                  op;
  tcc_pkg::op_t                  op_next;
  logic [tcc_pkg::GLYPH_W-1:0]   glyph;
  logic [tcc_pkg::GLYPH_W-1:0]   glyph_next;
  logic [tcc_pkg::POS_W-1:0]     col;
  logic [tcc_pkg::POS_W-1:0]     col_next;
  logic [tcc_pkg::POS_W-1:0]     row;
  logic [tcc_pkg::POS_W-1:0]     row_next;

  logic                          slot_free;
  logic                          at_bottom;
  logic                          wrap_due;
  logic                          emit;
  logic                          e_kind;
  logic [tcc_pkg::POS_W-1:0]     e_col;
  logic [tcc_pkg::POS_W-1:0]     e_row;
  logic [tcc_pkg::GLYPH_W-1:0]   e_glyph;
  logic                          e_last;

  assign slot_free = !events.valid || events.ready;
  assign at_bottom = (row >= ROW_LAST);
  assign wrap_due  = (col >= COL_LIMIT);

  // Step the sequencer, one result at most per cycle
  always_comb begin
    state_next = state;
    op_next    = op;
    glyph_next = glyph;
    col_next   = col;
    row_next   = row;
    pop        = 1'b0;
    emit       = 1'b0;
    e_kind     = tcc_pkg::EV_DRAW;
    e_col      = '0;
    e_row      = '0;
    e_glyph    = tcc_pkg::GLYPH_SPACE;
    e_last     = 1'b0;
    unique case (state)
      tcc_pkg::S_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          op_next    = pop_cmd.op;
          glyph_next = pop_cmd.glyph;
          state_next = tcc_pkg::S_RUN;
        end
      end
      tcc_pkg::S_RUN: begin
        if (slot_free) begin
          unique case (op)
            tcc_pkg::OP_LF: begin
              col_next   = '0;
              state_next = tcc_pkg::S_IDLE;
              if (at_bottom) begin
                emit   = 1'b1;
                e_kind = tcc_pkg::EV_SCROLL;
                e_last = 1'b1;
              end else begin
                row_next = row + 1'b1;
              end
            end
            tcc_pkg::OP_CR: begin
              col_next   = '0;
              state_next = tcc_pkg::S_IDLE;
            end
            tcc_pkg::OP_BS: begin
              if (col != '0) begin
                col_next = col - 1'b1;
              end
              state_next = tcc_pkg::S_IDLE;
            end
            tcc_pkg::OP_GLYPH, tcc_pkg::OP_TAB: begin
              if (wrap_due) begin
                // Wrap first: new line, scroll if at the bottom
                col_next = '0;
                if (at_bottom) begin
                  emit   = 1'b1;
                  e_kind = tcc_pkg::EV_SCROLL;
                end else begin
                  row_next = row + 1'b1;
                end
              end else begin
                emit     = 1'b1;
                e_kind   = tcc_pkg::EV_DRAW;
                e_col    = col;
                e_row    = row;
                e_glyph  = glyph;
                col_next = col + 1'b1;
                e_last   = (op == tcc_pkg::OP_GLYPH) || ((col_next[2:0] & tcc_pkg::TAB_MASK) == '0);
                if (e_last) begin
                  state_next = tcc_pkg::S_IDLE;
                end
              end
            end
            default: begin
              state_next = tcc_pkg::S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = tcc_pkg::S_IDLE;
      end
    endcase
  end

  // Hold control and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcc_pkg::S_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

  // Hold the current command
  always_ff @(posedge clk) begin
    op    <= op_next;
    glyph <= glyph_next;
  end

  // Output register: load when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      events.valid <= 1'b0;
    end else if (slot_free) begin
      events.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      events.event_kind  <= e_kind;
      events.cell_column <= e_col;
      events.cell_row    <= e_row;
      events.glyph_code  <= e_glyph;
      events.last_of_run <= e_last;
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= COL_LIMIT) else $error("cursor column past wrap point");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= ROW_LAST) else $error("cursor row past last row");

  a_draw_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (slot_free && emit && e_kind == tcc_pkg::EV_DRAW) |=>
      (events.cell_column < COL_LIMIT && events.cell_row <= ROW_LAST))
    else $error("draw word outside the screen");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == tcc_pkg::S_RUN)) else $error("command taken but sequencer not running");

endmodule

/* design/text_console_cursor_control_core.sv */
// Top level of the text console cursor control core.
//
//  channel  | dir | words                       | handshake
//  ---------+-----+-----------------------------+-------------
//  console  | in  | char_in                     | valid/ready
//  events   | out | event_kind, cell_column,    | valid/ready
//           |     | cell_row, glyph_code,       |
//           |     | last_of_run                 |
//
// A byte is taken while the command queue is not full and queued as a
// command (escape bytes, bell and bytes inside a CSI sequence queue
// nothing). The back end loads a command while idle, then emits its result
// words, with a wrap step (a scroll word at the bottom row) before a word
// past the last column; a tab draws spaces to the next eight-column stop.
// Reset is synchronous and clears the escape phase, cursor and queue.
// A stalled events port holds the back end; the front keeps taking bytes
// until the four-entry command queue fills.
module text_console_cursor_control_core #(
  parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
  input  logic      clk,
  input  logic      rst,
  tcc_in_if.sink    console,
  tcc_out_if.source events
);

  tcc_pkg::q_status_t q_status;
  tcc_pkg::cmd_t      push_cmd;
  tcc_pkg::cmd_t      pop_cmd;
  logic               push;
  logic               pop;

  tcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .console  (console),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  tcc_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_cmd  (pop_cmd),
    .pop      (pop),
    .events   (events)
  );

endmodule
